[rtl/core/hcio_pkg.sv]
// Shared constants and types for the handheld console I/O register file.
package hcio_pkg;

    typedef logic [7:0] t_byte;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_TIMER = 2'd1;
    localparam logic [1:0] EV_LCD   = 2'd2;
    localparam logic [1:0] EV_AUDIO = 2'd3;

    localparam logic [1:0] BK_NONE = 2'd0;
    localparam logic [1:0] BK_VRAM = 2'd1;
    localparam logic [1:0] BK_WRAM = 2'd2;

    localparam int PAL_DEPTH = 64;
    localparam int PAL_AW    = $clog2(PAL_DEPTH);
    localparam int PAGE_DEPTH = 256;

    localparam t_byte A_JOYP = 8'h00;
    localparam t_byte A_SC   = 8'h02;
    localparam t_byte A_DIV  = 8'h04;
    localparam t_byte A_TAC  = 8'h07;
    localparam t_byte A_NR10 = 8'h10;
    localparam t_byte A_NR11 = 8'h11;
    localparam t_byte A_NR12 = 8'h12;
    localparam t_byte A_NR13 = 8'h13;
    localparam t_byte A_NR14 = 8'h14;
    localparam t_byte A_NR15 = 8'h15;
    localparam t_byte A_NR16 = 8'h16;
    localparam t_byte A_NR17 = 8'h17;
    localparam t_byte A_NR18 = 8'h18;
    localparam t_byte A_NR19 = 8'h19;
    localparam t_byte A_NR30 = 8'h1a;
    localparam t_byte A_NR31 = 8'h1b;
    localparam t_byte A_NR32 = 8'h1c;
    localparam t_byte A_NR33 = 8'h1d;
    localparam t_byte A_NR34 = 8'h1e;
    localparam t_byte A_NR35 = 8'h1f;
    localparam t_byte A_NR41 = 8'h20;
    localparam t_byte A_NR42 = 8'h21;
    localparam t_byte A_NR44 = 8'h23;
    localparam t_byte A_NR51 = 8'h25;
    localparam t_byte A_NR52 = 8'h26;
    localparam t_byte A_AUXLO = 8'h27;
    localparam t_byte A_AUXHI = 8'h2f;
    localparam t_byte A_LCDC = 8'h40;
    localparam t_byte A_STAT = 8'h41;
    localparam t_byte A_LY   = 8'h44;
    localparam t_byte A_DMA  = 8'h46;
    localparam t_byte A_KEY1 = 8'h4d;
    localparam t_byte A_VBK  = 8'h4f;
    localparam t_byte A_HDMA5 = 8'h55;
    localparam t_byte A_RP   = 8'h56;
    localparam t_byte A_BCPS = 8'h68;
    localparam t_byte A_BCPD = 8'h69;
    localparam t_byte A_OCPS = 8'h6a;
    localparam t_byte A_OCPD = 8'h6b;
    localparam t_byte A_SVBK = 8'h70;
    localparam t_byte A_U71  = 8'h71;
    localparam t_byte A_U75  = 8'h75;
    localparam t_byte A_U76  = 8'h76;

    function automatic logic unmapped_common(input t_byte a);
        return a == 8'h03 || (a >= 8'h08 && a <= 8'h0e) || a == 8'h4c || a == 8'h4e ||
               (a >= 8'h57 && a <= 8'h67) || (a >= 8'h6d && a <= 8'h6f) ||
               (a >= 8'h77 && a <= 8'h7f);
    endfunction

endpackage

[rtl/core/hcio_if.sv]
// Request and response channel interfaces of the I/O register file.
interface hcio_req_if
    import hcio_pkg::*;
();
    logic        valid;
    logic        ready;
    logic        op;
    logic [7:0]  reg_addr;
    logic [7:0]  write_byte;
    logic [7:0]  keys_pressed;
    logic [31:0] cycle_now;
    logic        fast_mode;

    modport source (output valid, op, reg_addr, write_byte, keys_pressed, cycle_now,
                    fast_mode, input ready);
    modport sink (input valid, op, reg_addr, write_byte, keys_pressed, cycle_now,
                  fast_mode, output ready);
endinterface

interface hcio_rsp_if
    import hcio_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [7:0] read_byte;
    logic       bad_access;
    logic [1:0] restart_event;
    logic [1:0] bank_kind;
    logic [2:0] bank_number;

    modport source (output valid, read_byte, bad_access, restart_event, bank_kind,
                    bank_number, input ready);
    modport sink (input valid, read_byte, bad_access, restart_event, bank_kind,
                  bank_number, output ready);
endinterface

[rtl/core/handheld_console_io_register_file_unit.sv]
// Top level of the handheld console I/O register file.
// Usage:
//   i_req carries one byte access per transaction (read or write, address in
//   the 0xFF00 page, write data, key states, cycle count, speed mode).
//   o_rsp returns exactly one result transaction per request: read data,
//   failure flag, restart pulse code and bank-select report.
// Sequencing:
//   A request is accepted in S_IDLE; the page and palette memories are read
//   in the acceptance cycle, and the result is formed and the write-back
//   made in the next (S_RD), where the result is also registered.
//   A new request is taken only after the result is registered, so the
//   block never works on two requests at once; this is set by the
//   read-modify-write through the single page memory port.
//   Turning audio power off adds a clearing pass over 0x10-0x25.
// Reset:
//   Synchronous reset clears the registers and starts a clearing pass over
//   the page and palette memories; requests wait until it ends.
// Stall:
//   The result is held in the output register while o_rsp.ready is low; no
//   new request is taken until it has been delivered or is leaving that cycle.
module handheld_console_io_register_file_unit
    import hcio_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    hcio_req_if.sink      i_req,
    hcio_rsp_if.source    o_rsp
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_CLR  = 2'd2;

    logic [1:0] r_state;
    t_byte      r_clr, r_clr_end;
    logic       r_clr_pal;

    t_byte r_page [PAGE_DEPTH];
    t_byte r_bg   [PAL_DEPTH];
    t_byte r_obj  [PAL_DEPTH];

    t_byte r_page_q, r_bg_q, r_obj_q;

    logic        r_op, r_fast;
    t_byte       r_addr, r_wb, r_keys;
    logic [31:0] r_cyc;

    t_byte r_nr52, r_lcdc, r_stat, r_ly, r_bcps, r_ocps;
    t_byte n_nr52, n_lcdc, n_stat, n_ly, n_bcps, n_ocps;
    logic [31:0] r_off, n_off;

    logic       r_ov;
    t_byte      r_rd;
    logic       r_bad;
    logic [1:0] r_ev, r_bk;
    logic [2:0] r_bn;
    t_byte      n_rd;
    logic       n_bad;
    logic [1:0] n_ev, n_bk;
    logic [2:0] n_bn;

    logic  w_accept, w_we, w_bg_we, w_obj_we, w_aud_clr;
    t_byte w_wd, w_raddr, m, pb, po, v, t, w_hd;
    logic [31:0] w_div;

    assign i_req.ready = (r_state == S_IDLE) && (!r_ov || o_rsp.ready);
    assign w_accept    = i_req.valid && i_req.ready;

    always_comb begin
        w_raddr = i_req.reg_addr;
        if (i_req.op == OP_WRITE) begin
            unique case (i_req.reg_addr)
                A_NR14:  w_raddr = A_NR12;
                A_NR19:  w_raddr = A_NR17;
                A_NR34:  w_raddr = A_NR30;
                A_NR44:  w_raddr = A_NR42;
                default: w_raddr = i_req.reg_addr;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_page_q  <= r_page[w_raddr];
            r_bg_q    <= r_bg[r_bcps[PAL_AW-1:0]];
            r_obj_q   <= r_obj[r_ocps[PAL_AW-1:0]];
            r_op   <= i_req.op;
            r_addr <= i_req.reg_addr;
            r_wb   <= i_req.write_byte;
            r_keys <= i_req.keys_pressed;
            r_cyc  <= i_req.cycle_now;
            r_fast <= i_req.fast_mode;
        end
        if (w_we) r_page[r_addr] <= w_wd;
        else if (r_state == S_CLR) r_page[r_clr] <= 8'h00;
        if (w_bg_we) r_bg[r_bcps[PAL_AW-1:0]] <= r_wb;
        else if (r_state == S_CLR && r_clr_pal) r_bg[r_clr[PAL_AW-1:0]] <= 8'h00;
        if (w_obj_we) r_obj[r_ocps[PAL_AW-1:0]] <= r_wb;
        else if (r_state == S_CLR && r_clr_pal) r_obj[r_clr[PAL_AW-1:0]] <= 8'h00;
    end

    assign m  = r_page_q;
    assign pb = r_bg_q;
    assign po = r_obj_q;
    assign w_div = r_cyc - r_off;
    assign t  = ~r_keys;
    assign w_hd = (m != 8'hff) ? (8'h80 | (m & 8'h7f)) : 8'hff;

    always_comb begin
        n_rd = 8'h00; n_bad = 1'b0; n_ev = EV_NONE; n_bk = BK_NONE; n_bn = 3'd0;
        w_we = 1'b0; w_wd = r_wb; w_bg_we = 1'b0; w_obj_we = 1'b0; w_aud_clr = 1'b0;
        n_nr52 = r_nr52; n_lcdc = r_lcdc; n_stat = r_stat; n_ly = r_ly;
        n_bcps = r_bcps; n_ocps = r_ocps; n_off = r_off;
        v = r_wb;
        if (r_state == S_RD) begin
            if (r_op == OP_READ) begin
                priority if (unmapped_common(r_addr) || (r_addr >= A_AUXLO &&
                             r_addr <= A_AUXHI) || r_addr == A_U71 || r_addr == A_U76) begin
                    n_bad = 1'b1;
                end else begin
                    unique case (r_addr)
                        A_JOYP: begin
                            unique case (m[5:4])
                                2'b01:   n_rd = (m & 8'hf0) | {4'h0, t[7:4]};
                                2'b10:   n_rd = (m & 8'hf0) | {4'h0, t[3:0]};
                                2'b00:   n_rd = 8'hf0;
                                default: n_rd = 8'h00;
                            endcase
                        end
                        A_DIV:  n_rd = w_div[13:6];
                        A_BCPD: n_rd = pb;
                        A_OCPD: n_rd = po;
                        A_KEY1: n_rd = {r_fast, 6'd0, m[0]};
                        A_NR10: n_rd = 8'h80 | m;
                        A_NR11, A_NR16: n_rd = 8'h3f | m;
                        A_NR13, A_NR15, A_NR18, A_NR31, A_NR33, A_NR35, A_NR41:
                            n_rd = 8'hff;
                        A_NR14, A_NR19, A_NR34, A_NR44: n_rd = 8'hbf | m;
                        A_NR30: n_rd = 8'h7f | m;
                        A_NR32: n_rd = 8'h9f | m;
                        A_NR52: n_rd = 8'h70 | r_nr52;
                        A_LCDC: n_rd = r_lcdc;
                        A_STAT: n_rd = r_stat;
                        A_LY:   n_rd = r_ly;
                        A_BCPS: n_rd = r_bcps;
                        A_OCPS: n_rd = r_ocps;
                        default: n_rd = m;
                    endcase
                end
            end else begin
                priority if (unmapped_common(r_addr)) begin
                    n_bad = 1'b1;
                end else if (r_addr >= A_NR10 && r_addr <= A_NR51 && !r_nr52[7]) begin
                    w_we = 1'b0;
                end else if (r_addr >= A_AUXLO && r_addr <= A_AUXHI) begin
                    w_we = 1'b1; w_wd = 8'hff;
                end else begin
                    w_we = 1'b1;
                    unique case (r_addr)
                        A_SC: if (r_wb[7]) begin
                            n_bad = 1'b1; w_we = 1'b0;
                        end
                        A_DIV: begin
                            n_off = r_cyc; w_we = 1'b0;
                        end
                        A_TAC: begin
                            v = r_wb & 8'h07;
                            if (!m[2] && v[2]) n_ev = EV_TIMER;
                        end
                        A_DMA: w_we = 1'b0;
                        A_LCDC: begin
                            w_we = 1'b0;
                            n_lcdc = r_wb;
                            if (r_lcdc[7] && !r_wb[7]) begin
                                n_stat = r_stat & 8'hf8; n_ly = 8'h00;
                            end else if (!r_lcdc[7] && r_wb[7]) begin
                                n_stat = (r_stat & 8'hfc) | 8'h02; n_ly = 8'h00;
                                n_ev = EV_LCD;
                            end
                        end
                        A_STAT: begin
                            w_we = 1'b0; n_stat = (r_wb & 8'hf8) | (r_stat & 8'h07);
                        end
                        A_LY: begin
                            w_we = 1'b0; n_ly = r_wb;
                        end
                        A_VBK: begin
                            v = r_wb | 8'hfe; n_bk = BK_VRAM; n_bn = {2'b00, r_wb[0]};
                        end
                        A_SVBK: begin
                            v = r_wb & 8'h07; n_bk = BK_WRAM; n_bn = r_wb[2:0];
                        end
                        A_HDMA5: begin
                            if (r_wb[7] && r_lcdc[7]) v = r_wb & 8'h7f;
                            else v = w_hd;
                        end
                        A_RP: v = ((r_wb[7:6] == 2'b11) ? 8'h02 : 8'h00) | (r_wb & 8'hc1);
                        A_BCPS: begin
                            w_we = 1'b0; n_bcps = r_wb;
                        end
                        A_OCPS: begin
                            w_we = 1'b0; n_ocps = r_wb;
                        end
                        A_BCPD: begin
                            w_we = 1'b0; w_bg_we = 1'b1;
                            if (r_bcps[7]) n_bcps = (r_bcps + 8'd1) & 8'hbf;
                        end
                        A_OCPD: begin
                            w_we = 1'b0; w_obj_we = 1'b1;
                            if (r_ocps[7]) n_ocps = (r_ocps + 8'd1) & 8'hbf;
                        end
                        A_KEY1: v = r_wb & 8'h01;
                        A_NR12: if (r_wb[7:3] == 5'd0) n_nr52[0] = 1'b0;
                        A_NR17: if (r_wb[7:3] == 5'd0) n_nr52[1] = 1'b0;
                        A_NR42: if (r_wb[7:3] == 5'd0) n_nr52[3] = 1'b0;
                        A_NR30: if (!r_wb[7]) n_nr52[2] = 1'b0;
                        A_NR14: if (r_wb[7] && m[7:3] != 5'd0) n_nr52[0] = 1'b1;
                        A_NR19: if (r_wb[7] && m[7:3] != 5'd0) n_nr52[1] = 1'b1;
                        A_NR34: if (r_wb[7] && m[7]) n_nr52[2] = 1'b1;
                        A_NR44: if (r_wb[7] && m[7:3] != 5'd0) n_nr52[3] = 1'b1;
                        A_NR52: begin
                            w_we = 1'b0;
                            if (r_wb[7]) begin
                                n_nr52 = r_nr52 | 8'h80; n_ev = EV_AUDIO;
                            end else if (r_nr52[7]) begin
                                n_nr52 = 8'h00; w_aud_clr = 1'b1;
                            end
                        end
                        A_U75: v = r_wb & 8'h70;
                        default: v = r_wb;
                    endcase
                    w_wd = v;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr <= 8'h00; r_clr_end <= 8'hff; r_clr_pal <= 1'b1;
            r_nr52 <= 8'h00; r_lcdc <= 8'h00; r_stat <= 8'h00; r_ly <= 8'h00;
            r_bcps <= 8'h00; r_ocps <= 8'h00; r_off <= 32'd0;
            r_ov <= 1'b0;
        end else begin
            r_nr52 <= n_nr52; r_lcdc <= n_lcdc; r_stat <= n_stat; r_ly <= n_ly;
            r_bcps <= n_bcps; r_ocps <= n_ocps; r_off <= n_off;
            unique case (r_state)
                S_IDLE: if (w_accept) r_state <= S_RD;
                S_RD: begin
                    if (w_aud_clr) begin
                        r_state <= S_CLR;
                        r_clr <= A_NR10; r_clr_end <= A_NR51; r_clr_pal <= 1'b0;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_CLR: begin
                    r_clr <= r_clr + 8'd1;
                    if (r_clr == r_clr_end) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            if (r_state == S_RD) r_ov <= 1'b1;
            else if (o_rsp.ready) r_ov <= 1'b0;
        end
        if (r_state == S_RD) begin
            r_rd <= n_rd; r_bad <= n_bad; r_ev <= n_ev; r_bk <= n_bk; r_bn <= n_bn;
        end
    end

    assign o_rsp.valid         = r_ov;
    assign o_rsp.read_byte     = r_rd;
    assign o_rsp.bad_access    = r_bad;
    assign o_rsp.restart_event = r_ev;
    assign o_rsp.bank_kind     = r_bk;
    assign o_rsp.bank_number   = r_bn;

endmodule

[rtl/core/hcio_chk.sv]
// Port-level assertion checker for the I/O register file, with its bind.
module hcio_chk
    import hcio_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_rd,
    input logic       i_bad,
    input logic [1:0] i_ev,
    input logic [1:0] i_bk,
    input logic [2:0] i_bn
);

    a_no_bank3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_bk != 2'd3) else $error("bank kind out of range");

    a_bad_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_bad |-> i_rd == 8'h00 && i_ev == EV_NONE && i_bk == BK_NONE)
        else $error("failed access reports side effects");

    a_vbk_num: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_bk == BK_VRAM |-> i_bn[2:1] == 2'b00)
        else $error("video bank number too large");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("request taken while result stalled");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_rd) && $stable(i_bk))
        else $error("stalled result changed");

endmodule

bind handheld_console_io_register_file_unit hcio_chk u_hcio_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_rd        (o_rsp.read_byte),
    .i_bad       (o_rsp.bad_access),
    .i_ev        (o_rsp.restart_event),
    .i_bk        (o_rsp.bank_kind),
    .i_bn        (o_rsp.bank_number)
);

[tb/tb.sv]
// Testbench for the handheld console I/O register file: directed table plus random accesses.
`timescale 1ns / 1ps
module tb
    import hcio_pkg::*;
();

    logic i_clk;
    logic i_rst_n;
    hcio_req_if req_if ();
    hcio_rsp_if rsp_if ();

    handheld_console_io_register_file_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    typedef struct packed {
        logic        op;
        logic [7:0]  addr;
        logic [7:0]  wdata;
        logic [7:0]  keys;
        logic [31:0] cyc;
        logic        fast;
    } t_access;

    typedef struct packed {
        logic [7:0] rdata;
        logic       bad;
        logic [1:0] ev;
        logic [1:0] bk;
        logic [2:0] bn;
    } t_result;

    typedef struct packed {
        t_access    acc;
        logic       has_exp;
        t_result    exp;
    } t_row;

    // predictor state
    logic [7:0]  page [256];
    logic [7:0]  bg_pal [64];
    logic [7:0]  obj_pal [64];
    logic [31:0] div_base;

    t_result expected_q[$];
    t_result typed_q[$];
    logic    typed_valid_q[$];
    int      n_fail;
    int      idle_cycles;
    int      send_idle_pct;
    int      recv_idle_pct;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic is_unmapped(input logic [7:0] a);
        return a == 8'h03 || (a >= 8'h08 && a <= 8'h0e) || a == 8'h4c || a == 8'h4e ||
               (a >= 8'h57 && a <= 8'h67) || (a >= 8'h6d && a <= 8'h6f) ||
               (a >= 8'h77 && a <= 8'h7f);
    endfunction

    function automatic t_result predict_access(input t_access x);
        t_result    r;
        logic [7:0] v;
        logic [7:0] k;
        logic [7:0] t;
        logic       aon;
        logic       store;
        r = '0;
        v = page[x.addr];
        if (x.op == OP_READ) begin
            if (is_unmapped(x.addr) || (x.addr >= A_AUXLO && x.addr <= A_AUXHI) ||
                x.addr == A_U71 || x.addr == A_U76) begin
                r.bad = 1'b1;
                return r;
            end
            k = ~x.keys;
            case (x.addr)
                A_JOYP: begin
                    case (v[5:4])
                        2'b01: r.rdata = {v[7:4], k[7:4]};
                        2'b10: r.rdata = {v[7:4], k[3:0]};
                        2'b00: r.rdata = 8'hf0;
                        default: r.rdata = 8'h00;
                    endcase
                end
                A_DIV: r.rdata = 8'((x.cyc - div_base) >> 6);
                A_BCPD: r.rdata = bg_pal[page[A_BCPS][5:0]];
                A_OCPD: r.rdata = obj_pal[page[A_OCPS][5:0]];
                A_KEY1: r.rdata = {x.fast, 6'b0, v[0]};
                A_NR10: r.rdata = 8'h80 | v;
                A_NR11, A_NR16: r.rdata = 8'h3f | v;
                A_NR13, A_NR15, A_NR18, A_NR31, A_NR33, A_NR35, A_NR41: r.rdata = 8'hff;
                A_NR14, A_NR19, A_NR34, A_NR44: r.rdata = 8'hbf | v;
                A_NR30: r.rdata = 8'h7f | v;
                A_NR32: r.rdata = 8'h9f | v;
                A_NR52: r.rdata = 8'h70 | v;
                default: r.rdata = v;
            endcase
            return r;
        end
        aon = page[A_NR52][7];
        v = x.wdata;
        store = 1'b1;
        if (is_unmapped(x.addr)) begin
            r.bad = 1'b1;
            return r;
        end
        if (x.addr >= A_NR10 && x.addr <= A_NR51 && !aon) return r;
        if (x.addr >= A_AUXLO && x.addr <= A_AUXHI) begin
            page[x.addr] = 8'hff;
            return r;
        end
        case (x.addr)
            A_SC: if (v[7]) begin
                r.bad = 1'b1;
                store = 1'b0;
            end
            A_DIV: begin
                div_base = x.cyc;
                store = 1'b0;
            end
            A_TAC: begin
                v = v & 8'h07;
                if (!page[A_TAC][2] && v[2]) r.ev = EV_TIMER;
            end
            A_DMA: store = 1'b0;
            A_LCDC: begin
                if (page[A_LCDC][7] && !v[7]) begin
                    page[A_STAT] = page[A_STAT] & 8'hf8;
                    page[A_LY] = 8'h00;
                end else if (!page[A_LCDC][7] && v[7]) begin
                    page[A_STAT] = (page[A_STAT] & 8'hfc) | 8'h02;
                    page[A_LY] = 8'h00;
                    r.ev = EV_LCD;
                end
            end
            A_STAT: v = (v & 8'hf8) | (page[A_STAT] & 8'h07);
            A_VBK: begin
                v = v | 8'hfe;
                r.bk = BK_VRAM;
                r.bn = {2'b0, v[0]};
            end
            A_SVBK: begin
                v = v & 8'h07;
                r.bk = BK_WRAM;
                r.bn = v[2:0];
            end
            A_HDMA5: begin
                if (v[7] && page[A_LCDC][7]) v = v & 8'h7f;
                else if (page[A_HDMA5] != 8'hff) v = 8'h80 | (page[A_HDMA5] & 8'h7f);
                else v = 8'hff;
            end
            A_RP: v = ((v[7:6] == 2'b11) ? 8'h02 : 8'h00) | (v & 8'hc1);
            A_BCPD: begin
                t = page[A_BCPS];
                bg_pal[t[5:0]] = v;
                if (t[7]) page[A_BCPS] = (t + 8'd1) & 8'hbf;
                store = 1'b0;
            end
            A_OCPD: begin
                t = page[A_OCPS];
                obj_pal[t[5:0]] = v;
                if (t[7]) page[A_OCPS] = (t + 8'd1) & 8'hbf;
                store = 1'b0;
            end
            A_KEY1: v = v & 8'h01;
            A_NR12: if ((v & 8'hf8) == 0) page[A_NR52][0] = 1'b0;
            A_NR17: if ((v & 8'hf8) == 0) page[A_NR52][1] = 1'b0;
            A_NR42: if ((v & 8'hf8) == 0) page[A_NR52][3] = 1'b0;
            A_NR30: if (!v[7]) page[A_NR52][2] = 1'b0;
            A_NR14: if (v[7] && (page[A_NR12] & 8'hf8) != 0) page[A_NR52][0] = 1'b1;
            A_NR19: if (v[7] && (page[A_NR17] & 8'hf8) != 0) page[A_NR52][1] = 1'b1;
            A_NR34: if (v[7] && page[A_NR30][7]) page[A_NR52][2] = 1'b1;
            A_NR44: if (v[7] && (page[A_NR42] & 8'hf8) != 0) page[A_NR52][3] = 1'b1;
            A_NR52: begin
                if (v[7]) begin
                    page[A_NR52][7] = 1'b1;
                    r.ev = EV_AUDIO;
                end else if (aon) begin
                    for (int i = 16; i <= 38; i++) page[i] = 8'h00;
                end
                store = 1'b0;
            end
            A_U75: v = v & 8'h70;
            default: ;
        endcase
        if (store) page[x.addr] = v;
        return r;
    endfunction

    task automatic send_access(input t_access x, input logic has_exp, input t_result ex);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.op         <= x.op;
        req_if.reg_addr   <= x.addr;
        req_if.write_byte <= x.wdata;
        req_if.keys_pressed <= x.keys;
        req_if.cycle_now  <= x.cyc;
        req_if.fast_mode  <= x.fast;
        expected_q.push_back(predict_access(x));
        typed_valid_q.push_back(has_exp);
        typed_q.push_back(ex);
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic t_access rand_access();
        t_access x;
        int      sel;
        x.op    = 1'($urandom_range(1, 0));
        x.wdata = 8'($urandom_range(255, 0));
        x.keys  = 8'($urandom_range(255, 0));
        x.cyc   = $urandom;
        x.fast  = 1'($urandom_range(1, 0));
        sel = $urandom_range(9, 0);
        if (sel < 3) x.addr = 8'($urandom_range(8'h26, 8'h10));
        else if (sel < 5) x.addr = 8'($urandom_range(8'h76, 8'h40));
        else if (sel < 6) x.addr = 8'h26;
        else if (sel < 7) x.addr = 8'($urandom_range(8'h07, 8'h00));
        else x.addr = 8'($urandom_range(255, 0));
        // keep serial writes mostly legal so they also get stored
        if (x.op == OP_WRITE && x.addr == A_SC && sel < 8) x.wdata[7] = 1'b0;
        return x;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_result got;
        t_result ex;
        t_result ty;
        logic    tv;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            got = {rsp_if.read_byte, rsp_if.bad_access, rsp_if.restart_event,
                   rsp_if.bank_kind, rsp_if.bank_number};
            if (expected_q.size() == 0) begin
                $error("unexpected result transaction %h", got);
                n_fail++;
            end else begin
                ex = expected_q.pop_front();
                ty = typed_q.pop_front();
                tv = typed_valid_q.pop_front();
                if (tv && ty != ex) begin
                    $error("table row disagrees with predictor: %h vs %h", ty, ex);
                    n_fail++;
                end
                if (got.rdata !== ex.rdata) begin
                    $error("read_byte expected %h got %h", ex.rdata, got.rdata);
                    n_fail++;
                end
                if (got.bad !== ex.bad) begin
                    $error("bad_access expected %h got %h", ex.bad, got.bad);
                    n_fail++;
                end
                if (got.ev !== ex.ev) begin
                    $error("restart_event expected %h got %h", ex.ev, got.ev);
                    n_fail++;
                end
                if (got.bk !== ex.bk) begin
                    $error("bank_kind expected %h got %h", ex.bk, got.bk);
                    n_fail++;
                end
                if (got.bn !== ex.bn) begin
                    $error("bank_number expected %h got %h", ex.bn, got.bn);
                    n_fail++;
                end
            end
        end
    end

    // receiver stalls
    always @(negedge i_clk) begin
        if (recv_idle_pct > 0) rsp_if.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
        else rsp_if.ready <= 1'b1;
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    function automatic t_row mk(input logic op, input logic [7:0] a, input logic [7:0] w,
                                input logic [7:0] k, input logic has,
                                input t_result ex);
        t_row r;
        r.acc = '{op: op, addr: a, wdata: w, keys: k, cyc: 32'hffff_ffff, fast: 1'b1};
        r.has_exp = has;
        r.exp = ex;
        return r;
    endfunction

    initial begin
        t_row    rows[$];
        t_access x;
        t_result z;
        z = '0;
        n_fail = 0;
        idle_cycles = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        div_base = '0;
        for (int i = 0; i < 256; i++) page[i] = 8'h00;
        for (int i = 0; i < 64; i++) begin
            bg_pal[i] = 8'h00;
            obj_pal[i] = 8'h00;
        end
        i_rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.op = OP_READ;
        req_if.reg_addr = '0;
        req_if.write_byte = '0;
        req_if.keys_pressed = '0;
        req_if.cycle_now = '0;
        req_if.fast_mode = 1'b0;
        rsp_if.ready = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        rows.push_back(mk(OP_READ, A_JOYP, 8'h00, 8'hff, 1'b1,
                          '{8'hf0, 1'b0, EV_NONE, BK_NONE, 3'd0}));
        rows.push_back(mk(OP_WRITE, A_JOYP, 8'h30, 8'h00, 1'b1, z));
        rows.push_back(mk(OP_READ, A_JOYP, 8'h00, 8'h00, 1'b1, z));
        rows.push_back(mk(OP_WRITE, A_JOYP, 8'hd0, 8'h00, 1'b0, z));
        rows.push_back(mk(OP_READ, A_JOYP, 8'h00, 8'h5a, 1'b0, z));
        rows.push_back(mk(OP_READ, 8'h03, 8'h00, 8'h00, 1'b1,
                          '{8'h00, 1'b1, EV_NONE, BK_NONE, 3'd0}));
        rows.push_back(mk(OP_READ, A_AUXLO, 8'h00, 8'h00, 1'b1,
                          '{8'h00, 1'b1, EV_NONE, BK_NONE, 3'd0}));
        rows.push_back(mk(OP_WRITE, 8'h7f, 8'hff, 8'h00, 1'b1,
                          '{8'h00, 1'b1, EV_NONE, BK_NONE, 3'd0}));
        rows.push_back(mk(OP_WRITE, A_SC, 8'h80, 8'h00, 1'b1,
                          '{8'h00, 1'b1, EV_NONE, BK_NONE, 3'd0}));
        rows.push_back(mk(OP_WRITE, A_AUXHI, 8'h00, 8'h00, 1'b1, z));
        rows.push_back(mk(OP_WRITE, A_NR11, 8'hff, 8'h00, 1'b1, z));
        rows.push_back(mk(OP_WRITE, A_NR52, 8'h80, 8'h00, 1'b1,
                          '{8'h00, 1'b0, EV_AUDIO, BK_NONE, 3'd0}));
        rows.push_back(mk(OP_WRITE, A_NR12, 8'hf0, 8'h00, 1'b0, z));
        rows.push_back(mk(OP_WRITE, A_NR14, 8'h80, 8'h00, 1'b0, z));
        rows.push_back(mk(OP_READ, A_NR52, 8'h00, 8'h00, 1'b1,
                          '{8'hf1, 1'b0, EV_NONE, BK_NONE, 3'd0}));
        rows.push_back(mk(OP_WRITE, A_NR52, 8'h00, 8'h00, 1'b1, z));
        rows.push_back(mk(OP_WRITE, A_TAC, 8'hff, 8'h00, 1'b1,
                          '{8'h00, 1'b0, EV_TIMER, BK_NONE, 3'd0}));
        rows.push_back(mk(OP_WRITE, A_LCDC, 8'h80, 8'h00, 1'b1,
                          '{8'h00, 1'b0, EV_LCD, BK_NONE, 3'd0}));
        rows.push_back(mk(OP_WRITE, A_STAT, 8'hff, 8'h00, 1'b0, z));
        rows.push_back(mk(OP_WRITE, A_VBK, 8'h01, 8'h00, 1'b1,
                          '{8'h00, 1'b0, EV_NONE, BK_VRAM, 3'd1}));
        rows.push_back(mk(OP_WRITE, A_SVBK, 8'hff, 8'h00, 1'b1,
                          '{8'h00, 1'b0, EV_NONE, BK_WRAM, 3'd7}));
        rows.push_back(mk(OP_WRITE, A_BCPS, 8'hbf, 8'h00, 1'b0, z));
        rows.push_back(mk(OP_WRITE, A_BCPD, 8'ha5, 8'h00, 1'b0, z));
        rows.push_back(mk(OP_WRITE, A_HDMA5, 8'h85, 8'h00, 1'b0, z));
        rows.push_back(mk(OP_WRITE, A_DIV, 8'h00, 8'h00, 1'b0, z));
        foreach (rows[i]) send_access(rows[i].acc, rows[i].has_exp, rows[i].exp);

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 32 : (ph == 1) ? 79 : 0;
            recv_idle_pct = (ph == 0) ? 79 : (ph == 1) ? 32 : 0;
            for (int n = 0; n < 134; n++) begin
                x = rand_access();
                send_access(x, 1'b0, z);
            end
        end
        req_if.valid <= 1'b0;
        recv_idle_pct = 0;
        while (expected_q.size() != 0 && idle_cycles < 5000) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (n_fail == 0 && expected_q.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule

[handheld_console_io_register_file_unit.f]
rtl/core/hcio_pkg.sv
rtl/core/hcio_if.sv
rtl/core/handheld_console_io_register_file_unit.sv
rtl/core/hcio_chk.sv
tb/tb.sv
